/* rtl/core/bba_pkg.sv */
package bba_pkg;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int IDX_W          = 12;
    localparam int INDEX_LIMIT    = 4096;
    localparam int WORD_BITS      = 64;
    localparam int OFF_W          = 6;
    localparam int CFG_AW         = 3;
    localparam int CFG_DW         = 32;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // register index taken from paddr[2]
    localparam logic REG_FIRST_DATA_BLOCK = 1'b0;

    typedef logic [IDX_W-1:0] t_index;
    typedef logic [WORD_BITS-1:0] t_word;

endpackage

/* rtl/core/bitmap_block_allocator_core.sv */
// Bitmap first-fit block allocator. One used bit per block is held in a 64-bit wide
// synchronous memory, one word per 64 blocks, next to a flip-flop summary that marks
// full words. An allocate request (tuser op 0) hands out the lowest clear block at or
// above first_data_block and sets its bit; a free request (op 1) clears the bit of
// tdata's block, or answers a range error when that block lies below first_data_block
// or beyond the store. Each request gives one result beat. The block takes one request
// at a time: a free reads and then rewrites its word, an allocate first checks the first
// data block's own word and, when that has no room, moves on to the next non-full word
// found in the summary, and an answer decided at acceptance (range error, first data
// block past the store) goes straight to the result. A result waiting at the output
// stalls the next one only at its final step. The bitmap reads as all clear straight
// out of reset with no clearing pass. Only blocks below 4096 are ever handed out.
module bitmap_block_allocator_core #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] block_index
    input  logic [0:0]  s_axis_tuser,   // [0] op
    // result
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [11:0] granted_index
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bba_pkg::CFG_AW-1:0]  paddr,
    input  logic [bba_pkg::CFG_DW-1:0]  pwdata,
    output logic [bba_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    import bba_pkg::*;

    localparam int END_BLK   = (NUM_BLOCKS < INDEX_LIMIT) ? NUM_BLOCKS : INDEX_LIMIT;
    localparam int WORDS     = (END_BLK + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int TAIL_BITS = END_BLK % WORD_BITS;
    localparam logic [WA_W-1:0] LAST_W = WA_W'(WORDS - 1);
    // bits past the end of the store in the last word count as used
    localparam t_word TAIL_MASK = (TAIL_BITS == 0) ? '0 : ({WORD_BITS{1'b1}} << TAIL_BITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK1,
        S_CHK2,
        S_FREE,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [IDX_W-1:0]   r_fdb;
    logic [WORDS-1:0]   r_full;
    logic [WORDS-1:0]   r_wvalid;
    logic               r_rd_ok;
    t_word              r_rdata;
    t_word              mem [WORDS];
    logic [WA_W-1:0]    r_cur_w;
    logic [WA_W-1:0]    r_nw;
    logic               r_nw_ok;
    logic [OFF_W-1:0]   r_bit;
    logic [IDX_W-1:0]   r_res_index;
    logic [1:0]         r_res_status;
    logic               r_out_valid;
    logic [IDX_W-1:0]   r_m_index;
    logic [1:0]         r_m_status;

    logic               in_acc;
    logic               in_op;
    logic [IDX_W-1:0]   in_idx;
    logic               fdb_past_end;
    logic               free_bad;
    logic [WA_W-1:0]    start_w;
    logic [WORDS-1:0]   cand;
    logic               nw_found;
    logic [WA_W-1:0]    nw_idx;
    t_word              word_data;
    t_word              eff;
    logic               bit_found;
    logic [OFF_W-1:0]   bit_idx;
    t_word              alloc_word;
    t_word              free_word;
    logic [IDX_W-1:0]   granted;
    logic               rd_en;
    logic [WA_W-1:0]    rd_addr;
    logic               w_en;
    logic [WA_W-1:0]    w_addr;
    t_word              w_data;
    logic               out_free;
    logic               cfg_wr;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign in_op  = s_axis_tuser[0];
    assign in_idx = s_axis_tdata[IDX_W-1:0];

    assign fdb_past_end = ({5'd0, r_fdb} >= 17'(END_BLK));
    assign free_bad     = (in_idx < r_fdb) || ({5'd0, in_idx} >= 17'(NUM_BLOCKS));
    assign start_w      = WA_W'(r_fdb[IDX_W-1:OFF_W]);

    // non-full words strictly above the start word
    always_comb begin
        for (int w = 0; w < WORDS; w++) begin
            cand[w] = !r_full[w] && (w > int'(r_fdb[IDX_W-1:OFF_W]));
        end
    end

    bba_ffs #(.W(WORDS)) u_word_find (
        .i_req   (cand),
        .o_found (nw_found),
        .o_idx   (nw_idx)
    );

    // never-written words read as all clear
    assign word_data = r_rd_ok ? r_rdata : '0;

    always_comb begin
        eff = word_data;
        if (r_state == S_CHK1) begin
            eff = eff | ((WORD_BITS'(1) << r_fdb[OFF_W-1:0]) - WORD_BITS'(1));
        end
        if (r_cur_w == LAST_W) begin
            eff = eff | TAIL_MASK;
        end
    end

    bba_ffs #(.W(WORD_BITS)) u_bit_find (
        .i_req   (~eff),
        .o_found (bit_found),
        .o_idx   (bit_idx)
    );

    assign alloc_word = word_data | (WORD_BITS'(1) << bit_idx);
    assign free_word  = word_data & ~(WORD_BITS'(1) << r_bit);
    assign granted    = IDX_W'({r_cur_w, bit_idx});

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = start_w;
        w_en    = 1'b0;
        w_addr  = r_cur_w;
        w_data  = alloc_word;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_ALLOC) begin
                        rd_en = !fdb_past_end;
                    end else begin
                        rd_en   = !free_bad;
                        rd_addr = WA_W'(in_idx[IDX_W-1:OFF_W]);
                    end
                end
            end
            S_CHK1: begin
                if (bit_found) begin
                    w_en = 1'b1;
                end else begin
                    rd_en   = r_nw_ok;
                    rd_addr = r_nw;
                end
            end
            S_CHK2: begin
                w_en = bit_found;
            end
            S_FREE: begin
                w_en   = 1'b1;
                w_data = free_word;
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // every write lands before the next request can issue its read
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign out_free = !r_out_valid || m_axis_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fdb        <= '0;
            r_full       <= '0;
            r_wvalid     <= '0;
            r_rd_ok      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr && paddr[2] == REG_FIRST_DATA_BLOCK) begin
                r_fdb <= pwdata[IDX_W-1:0];
            end
            if (rd_en) begin
                r_rd_ok <= r_wvalid[rd_addr];
            end
            if (w_en) begin
                r_wvalid[w_addr] <= 1'b1;
                if (r_state == S_FREE) begin
                    r_full[w_addr] <= 1'b0;
                end else begin
                    r_full[w_addr] <= &(w_data | ((w_addr == LAST_W) ? TAIL_MASK : '0));
                end
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_res_index <= '0;
                        if (in_op == OP_ALLOC) begin
                            r_cur_w <= start_w;
                            r_nw    <= nw_idx;
                            r_nw_ok <= nw_found;
                            if (fdb_past_end) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_CHK1;
                            end
                        end else begin
                            r_cur_w <= WA_W'(in_idx[IDX_W-1:OFF_W]);
                            r_bit   <= in_idx[OFF_W-1:0];
                            if (free_bad) begin
                                r_res_status <= ST_RANGE;
                                r_state      <= S_DONE;
                            end else begin
                                r_state <= S_FREE;
                            end
                        end
                    end
                end
                S_CHK1: begin
                    if (bit_found) begin
                        r_res_index  <= granted;
                        r_res_status <= ST_OK;
                        r_state      <= S_DONE;
                    end else if (r_nw_ok) begin
                        r_cur_w <= r_nw;
                        r_state <= S_CHK2;
                    end else begin
                        r_res_status <= ST_FULL;
                        r_state      <= S_DONE;
                    end
                end
                S_CHK2: begin
                    r_res_index  <= bit_found ? granted : '0;
                    r_res_status <= bit_found ? ST_OK : ST_FULL;
                    r_state      <= S_DONE;
                end
                S_FREE: begin
                    r_res_status <= ST_OK;
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_m_index   <= r_res_index;
                        r_m_status  <= r_res_status;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_m_index};
    assign m_axis_tuser  = r_m_status;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_FIRST_DATA_BLOCK) ? {20'd0, r_fdb} : '0;

    // summary said this word has room
    a_summary_coherent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK2) |-> bit_found)
        else $error("next-word search hit a full word");

    a_alloc_sets_one_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && (r_state == S_CHK1 || r_state == S_CHK2)) |-> $onehot(w_data ^ word_data))
        else $error("allocate write changed other than one clear bit");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |-> (r_state == S_CHK1 || r_state == S_CHK2 || r_state == S_FREE))
        else $error("bitmap write outside a modify step");

    a_index_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero index on a failed request");

    a_grant_above_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK1 && bit_found) |-> (granted >= r_fdb))
        else $error("grant below first data block");

endmodule

/* rtl/core/bba_ffs.sv */
module bba_ffs #(
    parameter int W = 64
) (
    input  logic [W-1:0]                       i_req,
    output logic                               o_found,
    output logic [((W > 1) ? $clog2(W) : 1)-1:0] o_idx
);

    localparam int IW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0] lowbit;

    // isolate the lowest set bit, then encode the one-hot word
    assign lowbit  = i_req & (~i_req + W'(1));
    assign o_found = |i_req;

    always_comb begin
        o_idx = '0;
        for (int i = 0; i < W; i++) begin
            if (lowbit[i]) begin
                o_idx = o_idx | IW'(i);
            end
        end
    end

endmodule

/* tb/sv/bba_result_checker.sv */
module bba_result_checker #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_req_valid,
    input  logic                        i_req_ready,
    input  logic [15:0]                 i_req_data,   // [11:0] block_index
    input  logic [0:0]                  i_req_user,   // [0] op
    input  logic                        i_res_valid,
    input  logic                        i_res_ready,
    input  logic [15:0]                 i_res_data,   // [11:0] granted_index
    input  logic [1:0]                  i_res_user,   // [1:0] status
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic                        i_pready,
    input  logic [bba_pkg::CFG_AW-1:0]  i_paddr,
    input  logic [bba_pkg::CFG_DW-1:0]  i_pwdata,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count,
    output int                          o_full_count,
    output int                          o_range_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam int SEARCH_END = (NUM_BLOCKS < INDEX_LIMIT) ? NUM_BLOCKS : INDEX_LIMIT;

    typedef struct packed {
        t_index     granted;
        logic [1:0] status;
    } t_answer;

    logic [NUM_BLOCKS-1:0] used_map;
    t_index                first_block;
    t_answer               pending_answers[$];

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        o_full_count   = 0;
        o_range_count  = 0;
        used_map       = '0;
        first_block    = '0;
    end

    // first-fit search on allocate, single-bit clear on free
    function automatic t_answer serve_request(logic op, t_index idx);
        t_answer ans;
        ans.granted = '0;
        if (op == OP_ALLOC) begin
            ans.status = ST_FULL;
            for (int b = int'(first_block); b < SEARCH_END; b++) begin
                if (!used_map[b]) begin
                    used_map[b] = 1'b1;
                    ans.granted = t_index'(b);
                    ans.status  = ST_OK;
                    break;
                end
            end
        end else if (idx < first_block || int'(idx) >= NUM_BLOCKS) begin
            ans.status = ST_RANGE;
        end else begin
            used_map[idx] = 1'b0;
            ans.status    = ST_OK;
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            used_map    = '0;
            first_block = '0;
            pending_answers.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                o_result_count++;
                if (pending_answers.size() == 0) begin
                    $error("result beat with no request outstanding: granted_index %0d status %0d",
                           i_res_data[IDX_W-1:0], i_res_user);
                    o_fail_count++;
                end else begin
                    want = pending_answers.pop_front();
                    if (i_res_data[IDX_W-1:0] !== want.granted) begin
                        $error("granted_index mismatch: expected %0d, actual %0d",
                               want.granted, i_res_data[IDX_W-1:0]);
                        o_fail_count++;
                    end
                    if (i_res_user !== want.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, i_res_user);
                        o_fail_count++;
                    end
                    if (want.status == ST_FULL)  o_full_count++;
                    if (want.status == ST_RANGE) o_range_count++;
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                    && i_paddr[2] == REG_FIRST_DATA_BLOCK)
                first_block = i_pwdata[IDX_W-1:0];
            if (i_req_valid && i_req_ready)
                pending_answers.push_back(serve_request(i_req_user[0],
                                                        i_req_data[IDX_W-1:0]));
        end
        o_pending = pending_answers.size();
    end

endmodule

/* tb/sv/tb_bitmap_block_allocator_core.sv */
module tb_bitmap_block_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;
    import bba_pkg::*;

    localparam int RANDOM_ITEMS = 1850;
    localparam int NUM_PHASES   = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE       = 8;

    localparam logic [CFG_AW-1:0] ADDR_FIRST_BLOCK = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_UNMAPPED    = 3'd4;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata  = '0;
    logic [0:0]         s_axis_tuser  = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;
    logic [1:0]         m_axis_tuser;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [CFG_AW-1:0]  paddr         = '0;
    logic [CFG_DW-1:0]  pwdata        = '0;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;

    int fail_count;
    int pending;
    int result_count;
    int full_count;
    int range_count;

    int cycle_count  = 0;
    int sent_count   = 0;
    int setting_count = 0;
    int snd_idle_pct = 14;
    int rcv_idle_pct = 84;
    int cur_first    = 0;

    bitmap_block_allocator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    bba_result_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (s_axis_tvalid),
        .i_req_ready    (s_axis_tready),
        .i_req_data     (s_axis_tdata),
        .i_req_user     (s_axis_tuser),
        .i_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .i_res_data     (m_axis_tdata),
        .i_res_user     (m_axis_tuser),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_full_count   (full_count),
        .o_range_count  (range_count)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    task automatic send_req(logic op, t_index idx);
        if (sent_count < RANDOM_ITEMS / 3) begin
            snd_idle_pct = 14;
            rcv_idle_pct = 84;
        end else if (sent_count < 2 * RANDOM_ITEMS / 3) begin
            snd_idle_pct = 84;
            rcv_idle_pct = 14;
        end else begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        sent_count++;
    endtask

    // block_index carries noise on allocate
    task automatic alloc_req();
        send_req(OP_ALLOC, t_index'($urandom));
    endtask

    task automatic free_req(int idx);
        send_req(OP_FREE, t_index'(idx));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
        drain();
        repeat (SETTLE) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_FIRST_DATA_BLOCK) begin
            cur_first = int'(data[IDX_W-1:0]);
            setting_count++;
        end
    endtask

    task automatic run_phase(int first, int n_items);
        logic [31:0] junk;
        int          pick;
        int          idx;
        junk = $urandom;
        write_reg(ADDR_FIRST_BLOCK, {junk[31:12], 12'(first)});
        for (int i = 0; i < n_items; i++) begin
            if (i == n_items / 2) drain();
            if ($urandom_range(0, 99) < 58) begin
                alloc_req();
            end else begin
                pick = $urandom_range(0, 99);
                // mostly frees near the allocation front, where blocks are in use
                if (pick < 65) begin
                    idx = cur_first + $urandom_range(0, 127);
                    if (idx > 4095) idx = 4095;
                end else if (pick < 80 && cur_first > 0) begin
                    idx = $urandom_range(0, cur_first - 1);
                end else begin
                    idx = $urandom_range(0, 4095);
                end
                free_req(idx);
            end
        end
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset value of first_data_block is zero
        alloc_req();
        alloc_req();
        free_req(0);
        free_req(0);
        alloc_req();
        free_req(4095);
        write_reg(ADDR_FIRST_BLOCK, 32'h0000_0FFF);
        alloc_req();
        alloc_req();
        free_req(4094);
        free_req(0);
        free_req(4095);
        alloc_req();
        // unmapped register index, must leave first_data_block alone
        write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        alloc_req();
        write_reg(ADDR_FIRST_BLOCK, 32'hFFFF_F03F);
        alloc_req();
        alloc_req();
        free_req(4095);
        alloc_req();
        free_req(63);
        alloc_req();

        run_phase(0, RANDOM_ITEMS / NUM_PHASES);
        run_phase(4032, RANDOM_ITEMS / NUM_PHASES);
        run_phase($urandom_range(0, 4095), RANDOM_ITEMS / NUM_PHASES);
        run_phase(4095, RANDOM_ITEMS / NUM_PHASES);
        run_phase(4000, RANDOM_ITEMS / NUM_PHASES);
        run_phase($urandom_range(1, 4094), RANDOM_ITEMS / NUM_PHASES);
        run_phase(64, RANDOM_ITEMS / NUM_PHASES);
        run_phase(0, RANDOM_ITEMS / NUM_PHASES);

        drain();
        repeat (SETTLE) @(negedge i_clk);

        $display("Ran %0d requests across %0d first_data_block settings and 3 idle mixes;",
                 sent_count, setting_count);
        $display("checked %0d result beats, %0d full answers, %0d range errors.",
                 result_count, full_count, range_count);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
